// ===== sv/rch_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rch_pkg: shared definitions for the region colour histogram
// Bin codes, counter sizing, the queued classification word and the
// reciprocal used to scale bins at emit time.
// ---------------------------------------------------------------------------
package rch_pkg;

    // Counter sizing: counters saturate at the smaller of the region size
    // limit and the largest value the count field can carry.
    localparam int CNT_W          = 21;
    localparam int MAX_REGION_PIX = 1048576;
    localparam int CNT_MAX_FIELD  = (1 << CNT_W) - 1;
    localparam int CNT_LIMIT_INT  = (MAX_REGION_PIX < CNT_MAX_FIELD) ?
                                    MAX_REGION_PIX : CNT_MAX_FIELD;
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_LIMIT_INT[CNT_W-1:0];

    localparam int NUM_BINS  = 9;
    localparam int NUM_WORDS = NUM_BINS + 1;
    localparam int IDX_W     = 4;

    // Bin codes as they appear on the result channel.
    localparam logic [IDX_W-1:0] BIN_RED     = 4'd0;
    localparam logic [IDX_W-1:0] BIN_ORANGE  = 4'd1;
    localparam logic [IDX_W-1:0] BIN_YELLOW  = 4'd2;
    localparam logic [IDX_W-1:0] BIN_GREEN   = 4'd3;
    localparam logic [IDX_W-1:0] BIN_BLUE    = 4'd4;
    localparam logic [IDX_W-1:0] BIN_MAGENTA = 4'd5;
    localparam logic [IDX_W-1:0] BIN_BLACK   = 4'd6;
    localparam logic [IDX_W-1:0] BIN_WHITE   = 4'd7;
    localparam logic [IDX_W-1:0] BIN_GRAY    = 4'd8;
    localparam logic [IDX_W-1:0] BIN_TOTAL   = 4'd9;

    // Queue between classifier and accumulator.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Division by ten through a reciprocal: floor(x / 10) = (x * M) >> 26,
    // exact for every numerator below 2^22.
    localparam int NUM_W     = CNT_W + 1;
    localparam int REC_W     = 23;
    localparam int REC_SHIFT = 26;
    localparam int PROD_W    = NUM_W + REC_W;
    localparam int QUOT_W    = PROD_W - REC_SHIFT;
    localparam logic [REC_W-1:0] REC_TEN = 23'd6710887;

    // Rounding offsets for ceil(n / 10) and ceil(n / 20).
    localparam logic [NUM_W-1:0] OFS_TENTH    = 22'd9;
    localparam logic [NUM_W-1:0] OFS_TWENTIETH = 22'd19;

    // One classified pixel as it travels through the queue.
    typedef struct packed {
        logic [NUM_BINS-1:0] hit;
        logic                counted;
        logic                last;
    } rch_word_t;

endpackage

// ===== sv/rch_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rch_front: pixel classifier
// Applies the hue, RGB fallback and neutral rules to one pixel and packs
// the resulting bin hits with the count and end-of-region marks.
// ---------------------------------------------------------------------------
module rch_front
    import rch_pkg::*;
(
    input  logic [7:0] s_hue,
    input  logic [7:0] s_red,
    input  logic [7:0] s_green,
    input  logic [7:0] s_blue,
    input  logic       s_pixel_valid,
    input  logic       s_region_end,
    output rch_word_t  word
);

    logic [7:0] h, r, g, b;
    logic [7:0] drg, dgb, dbr;
    logic [9:0] sum;
    logic       neutral, is_black, is_white;
    logic       hue_red, hue_orange, hue_yellow, hue_green, hue_blue, hue_magenta;
    logic       any_hue;
    logic       fb_red, fb_orange, fb_yellow, fb_green, fb_blue, fb_magenta;
    logic       gray_hit, blue_undo;
    logic [NUM_BINS-1:0] hit;

    assign h = s_hue;
    assign r = s_red;
    assign g = s_green;
    assign b = s_blue;

    // Pairwise distances and the component sum.
    assign drg = (r > g) ? r - g : g - r;
    assign dgb = (g > b) ? g - b : b - g;
    assign dbr = (b > r) ? b - r : r - b;
    assign sum = {2'b00, r} + {2'b00, g} + {2'b00, b};

    // Hue rules.
    assign hue_red     = (h >= 8'd177) || ((h <= 8'd3) && (r >= 8'd130));
    assign hue_orange  = (h >= 8'd5)   && (h <= 8'd25);
    assign hue_yellow  = (h >= 8'd20)  && (h <= 8'd40)  && (b <= 8'd130);
    assign hue_green   = (h >= 8'd45)  && (h <= 8'd80);
    assign hue_blue    = (h >= 8'd105) && (h <= 8'd132) && (b >= 8'd120);
    assign hue_magenta = (h >= 8'd144) && (h <= 8'd156);
    assign any_hue     = hue_red | hue_orange | hue_yellow | hue_green |
                         hue_blue | hue_magenta;

    // RGB fallback rules, used only when no hue rule matched.
    assign fb_red     = ((r >= 8'd150) && (g <= 8'd110) && (b <= 8'd110)) ||
                        ((r >= 8'd100) && (drg >= 8'd40) && (dbr >= 8'd40) &&
                         (g <= 8'd50) && (b <= 8'd50));
    assign fb_orange  = (r >= 8'd150) && (drg >= 8'd60) && (drg <= 8'd110) &&
                        (b <= 8'd110);
    assign fb_yellow  = (r >= 8'd150) && (g >= 8'd150) && (drg <= 8'd40) &&
                        (b <= 8'd80);
    assign fb_green   = ((g >= 8'd150) && (r <= 8'd110) && (b <= 8'd110)) ||
                        ((g >= 8'd80) && (drg >= 8'd40) && (dgb >= 8'd40) &&
                         (r <= 8'd50) && (b <= 8'd50));
    assign fb_blue    = ((b >= 8'd160) && (r <= 8'd110) && (g <= 8'd110)) ||
                        ((b >= 8'd100) && (dgb >= 8'd40) && (dbr >= 8'd40) &&
                         (r <= 8'd50) && (g <= 8'd50));
    assign fb_magenta = (r >= 8'd150) && (b >= 8'd150) && (dbr <= 8'd60) &&
                        (g <= 8'd110);

    // Neutral rules.
    assign neutral  = (drg < 8'd15) && (dgb < 8'd15) && (dbr < 8'd15);
    assign is_black = neutral && (sum <= 10'd70);
    assign is_white = neutral && (sum >= 10'd435);
    assign gray_hit = neutral && !is_black && !is_white &&
                      (r >= 8'd25) && (r <= 8'd50) &&
                      (g >= 8'd25) && (g <= 8'd50) &&
                      (b >= 8'd25) && (b <= 8'd50);

    // A hue blue hit on a black or white pixel in the lower blue band is
    // dropped; fallback blue never sets the mark, so it is never undone.
    assign blue_undo = hue_blue && (is_black || is_white) && (h <= 8'd125);

    // Combine into the hit vector.
    always_comb begin
        hit = '0;
        if (any_hue) begin
            hit[BIN_RED]     = hue_red;
            hit[BIN_ORANGE]  = hue_orange;
            hit[BIN_YELLOW]  = hue_yellow;
            hit[BIN_GREEN]   = hue_green;
            hit[BIN_BLUE]    = hue_blue && !blue_undo;
            hit[BIN_MAGENTA] = hue_magenta;
        end else begin
            hit[BIN_RED]     = fb_red;
            hit[BIN_ORANGE]  = fb_orange;
            hit[BIN_YELLOW]  = fb_yellow;
            hit[BIN_GREEN]   = fb_green;
            hit[BIN_BLUE]    = fb_blue;
            hit[BIN_MAGENTA] = fb_magenta;
        end
        hit[BIN_BLACK] = is_black;
        hit[BIN_WHITE] = is_white;
        hit[BIN_GRAY]  = gray_hit;
    end

    // Pixels outside the foreground touch no counter.
    assign word.hit     = s_pixel_valid ? hit : '0;
    assign word.counted = s_pixel_valid;
    assign word.last    = s_region_end;

endmodule

// ===== sv/rch_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rch_queue: short queue of classified words
// A small register queue that lets the classifier and the accumulator
// stall independently of each other.
// ---------------------------------------------------------------------------
module rch_queue
    import rch_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      i_valid,
    output logic      i_ready,
    input  rch_word_t i_word,
    output logic      o_valid,
    input  logic      o_ready,
    output rch_word_t o_word
);

    rch_word_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              push, pop;

    assign i_ready = (fill_reg != QUEUE_DEPTH[QCNT_W-1:0]);
    assign o_valid = (fill_reg != '0);
    assign o_word  = mem_reg[rd_ptr_reg];
    assign push    = i_valid && i_ready;
    assign pop     = o_valid && o_ready;

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= i_word;
        end
    end

endmodule

// ===== sv/rch_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rch_back: bin accumulator and result emitter
// Adds classified words into saturating counters, snapshots them at region end
// and sends the ten result words, three scaled, through a two-stage pipeline.
// ---------------------------------------------------------------------------
module rch_back
    import rch_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_ready,
    input  rch_word_t        q_word,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [IDX_W-1:0] m_bin_index,
    output logic [CNT_W-1:0] m_bin_count,
    output logic             m_final_bin
);

    logic [CNT_W-1:0] cnt_reg  [NUM_BINS];
    logic [CNT_W-1:0] cnt_upd  [NUM_BINS];
    logic [CNT_W-1:0] tot_reg, tot_upd;
    logic [CNT_W-1:0] snap_reg [NUM_WORDS];
    logic             busy_reg;
    logic [IDX_W-1:0] emit_idx_reg;
    logic             pop, issue;

    // Scaling stage.
    logic              a_valid_reg;
    logic [IDX_W-1:0]  a_idx_reg;
    logic [CNT_W-1:0]  a_n_reg;
    logic [PROD_W-1:0] a_prod_reg;
    logic              a_load;
    logic [CNT_W-1:0]  sel_n;
    logic [NUM_W-1:0]  sel_num;

    // Output stage.
    logic              o_valid_reg;
    logic [IDX_W-1:0]  o_idx_reg;
    logic [CNT_W-1:0]  o_cnt_reg;
    logic              o_load;
    logic [QUOT_W-1:0] quot_ten;
    logic [CNT_W-1:0]  ceil_part;
    logic [CNT_W-1:0]  scaled;

    // A region end waits until the previous snapshot has been issued.
    assign q_ready = !(q_word.last && busy_reg);
    assign pop     = q_valid && q_ready;

    // Saturating increments for the word being taken.
    always_comb begin
        for (int k = 0; k < NUM_BINS; k++) begin
            cnt_upd[k] = cnt_reg[k];
            if (pop && q_word.hit[k] && (cnt_reg[k] < CNT_LIMIT)) begin
                cnt_upd[k] = cnt_reg[k] + 1'b1;
            end
        end
        tot_upd = tot_reg;
        if (pop && q_word.counted && (tot_reg < CNT_LIMIT)) begin
            tot_upd = tot_reg + 1'b1;
        end
    end

    // Counters clear as the region's totals move into the snapshot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_BINS; k++) begin
                cnt_reg[k] <= '0;
            end
            tot_reg <= '0;
        end else if (pop && q_word.last) begin
            for (int k = 0; k < NUM_BINS; k++) begin
                cnt_reg[k] <= '0;
            end
            tot_reg <= '0;
        end else begin
            for (int k = 0; k < NUM_BINS; k++) begin
                cnt_reg[k] <= cnt_upd[k];
            end
            tot_reg <= tot_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && q_word.last) begin
            for (int k = 0; k < NUM_BINS; k++) begin
                snap_reg[k] <= cnt_upd[k];
            end
            snap_reg[NUM_BINS] <= tot_upd;
        end
    end

    // Emit sequencing: one snapshot word enters the pipeline per free slot.
    assign o_load = a_valid_reg && (!o_valid_reg || m_ready);
    assign a_load = !a_valid_reg || o_load;
    assign issue  = busy_reg && a_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            emit_idx_reg <= '0;
        end else if (pop && q_word.last) begin
            busy_reg     <= 1'b1;
            emit_idx_reg <= '0;
        end else if (issue) begin
            emit_idx_reg <= emit_idx_reg + 1'b1;
            if (emit_idx_reg == BIN_TOTAL) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Numerator for ceil(n/10) or, halved later, ceil(n/20).
    always_comb begin
        sel_n = snap_reg[emit_idx_reg];
        case (emit_idx_reg)
            BIN_BLACK: sel_num = {1'b0, sel_n} + OFS_TENTH;
            BIN_WHITE,
            BIN_BLUE:  sel_num = {1'b0, sel_n} + OFS_TWENTIETH;
            default:   sel_num = {1'b0, sel_n};
        endcase
    end

    // Scaling stage holds the reciprocal product.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_load) begin
            a_valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            a_idx_reg  <= emit_idx_reg;
            a_n_reg    <= sel_n;
            a_prod_reg <= PROD_W'(sel_num) * PROD_W'(REC_TEN);
        end
    end

    // Black, white and blue are n minus the rounded-up fraction; others pass n.
    always_comb begin
        quot_ten = a_prod_reg[PROD_W-1:REC_SHIFT];
        if (a_idx_reg == BIN_BLACK) begin
            ceil_part = CNT_W'(quot_ten);
        end else begin
            ceil_part = CNT_W'(quot_ten >> 1);
        end
        case (a_idx_reg)
            BIN_BLACK,
            BIN_WHITE,
            BIN_BLUE: scaled = a_n_reg - ceil_part;
            default:  scaled = a_n_reg;
        endcase
    end

    // Output register towards the result channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (o_load) begin
            o_valid_reg <= 1'b1;
        end else if (m_ready) begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_load) begin
            o_idx_reg <= a_idx_reg;
            o_cnt_reg <= scaled;
        end
    end

    assign m_valid     = o_valid_reg;
    assign m_bin_index = o_idx_reg;
    assign m_bin_count = o_cnt_reg;
    assign m_final_bin = (o_idx_reg == BIN_TOTAL);

endmodule

// ===== sv/region_color_histogram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// region_color_histogram: colour histogram of one image region
// Classifies pixels into nine colour bins and, at region end, emits the
// bins, black, white and blue scaled, then the counted-pixel total.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Word contents
//  s_*      in         hue, red, green, blue, pixel_valid, region_end
//  m_*      out        bin_index, bin_count, final_bin
//
// One pixel word is taken every cycle while s_ready is high; the classifier, a
// four-entry queue and the accumulating counters keep pace with no bubbles.
// A region end snapshots the counters, which clear at once, so the next
// region flows in while its ten result words leave one per cycle, as long
// as m_ready is high, through a scaling stage and an output register, which
// the first word passes in that order after the snapshot.
// A further region end waits in the queue until the tenth word of the
// previous region has entered the scaling stage.
// Reset is synchronous and clears all counters and control state; a stall
// on the result side backs up into the queue and then to s_ready.
// ---------------------------------------------------------------------------
module region_color_histogram
    import rch_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_hue,
    input  logic [7:0]       s_red,
    input  logic [7:0]       s_green,
    input  logic [7:0]       s_blue,
    input  logic             s_pixel_valid,
    input  logic             s_region_end,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [IDX_W-1:0] m_bin_index,
    output logic [CNT_W-1:0] m_bin_count,
    output logic             m_final_bin
);

    rch_word_t front_word;
    rch_word_t q_word;
    logic      q_valid;
    logic      q_ready;

    // Classification of the incoming pixel.
    rch_front u_front (
        .s_hue         (s_hue),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .s_pixel_valid (s_pixel_valid),
        .s_region_end  (s_region_end),
        .word          (front_word)
    );

    // Decoupling queue.
    rch_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .i_valid (s_valid),
        .i_ready (s_ready),
        .i_word  (front_word),
        .o_valid (q_valid),
        .o_ready (q_ready),
        .o_word  (q_word)
    );

    // Accumulation and emit.
    rch_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_word      (q_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_bin_index (m_bin_index),
        .m_bin_count (m_bin_count),
        .m_final_bin (m_final_bin)
    );

endmodule
